// ===== src/xb64_pkg.sv =====
// shared types and constants of the xor base64 codec
package xb64_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_KEY_LOW   = 2'd1,
    REG_KEY_HIGH  = 2'd2,
    REG_KEY_LEN   = 2'd3
  } reg_index_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_t;

  // one accepted item's results: up to four bytes, sent in order
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
    logic            err;
  } xb64_rec_t;

endpackage

// ===== src/xb64_front.sv =====
// front end: config registers, key stepping, group assembly and error checks
module xb64_front #(
  parameter int KEY_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output xb64_pkg::xb64_rec_t q_rec
);
  import xb64_pkg::*;

  localparam logic [4:0] KEY_LEN_MAX = 5'(KEY_BYTES);
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_DIGIT = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  dir_t        dir_r;
  logic [63:0] key_lo_r;
  logic [63:0] key_hi_r;
  logic [4:0]  key_len_r;

  logic [3:0]  key_pos_r, key_pos_nxt;
  logic [23:0] gbuf_r, gbuf_nxt;
  logic [1:0]  gcnt_r, gcnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        disc_r, disc_nxt;

  function automatic logic [3:0] key_norm(input logic [3:0] p, input logic [4:0] len);
    key_norm = ({1'b0, p} >= len) ? 4'd0 : p;
  endfunction

  function automatic logic [3:0] key_adv(input logic [3:0] p, input logic [4:0] len);
    key_adv = (({1'b0, p} + 5'd1) >= len) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    r = 8'h00;
    if (v < 6'd26) r = CH_UPPER + {2'b00, v};
    else if (v < 6'd52) r = CH_LOWER + {2'b00, v} - 8'd26;
    else if (v < 6'd62) r = CH_DIGIT + {2'b00, v} - 8'd52;
    else if (v == 6'd62) r = CH_PLUS;
    else r = CH_SLASH;
    return r;
  endfunction

  // bit 6 set for a valid base64 character
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == CH_PLUS) r = {1'b1, 6'd62};
    else if (c == CH_SLASH) r = {1'b1, 6'd63};
    return r;
  endfunction

  logic [4:0]   len;
  logic [127:0] key_all;
  logic [3:0]   p0, p1, p2, p3;
  logic [7:0]   kb0, kb1, kb2;
  logic         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len = key_len_r;
    if (len == 5'd0) len = 5'd1;
    if (len > KEY_LEN_MAX) len = KEY_LEN_MAX;
    key_all = {key_hi_r, key_lo_r};
    p0 = key_norm(key_pos_r, len);
    p1 = key_adv(p0, len);
    p2 = key_adv(p1, len);
    p3 = key_adv(p2, len);
    kb0 = key_all[{p0, 3'b000} +: 8];
    kb1 = key_all[{p1, 3'b000} +: 8];
    kb2 = key_all[{p2, 3'b000} +: 8];
  end

  logic [1:0]  ecnt;
  logic [2:0]  ecnt1;
  logic [23:0] ebuf;
  logic [23:0] eval_w;
  logic [6:0]  dec;
  logic [5:0]  sv;
  logic [2:0]  dpos;
  logic        bad;
  logic [1:0]  dpad;
  logic [23:0] dbuf;
  logic [1:0]  dbytes;

  always_comb begin
    key_pos_nxt = key_pos_r;
    gbuf_nxt    = gbuf_r;
    gcnt_nxt    = gcnt_r;
    pad_nxt     = pad_r;
    disc_nxt    = disc_r;
    q_push      = 1'b0;
    q_rec       = '0;
    ecnt        = 2'd0;
    ecnt1       = 3'd0;
    ebuf        = 24'd0;
    eval_w      = 24'd0;
    dec         = 7'd0;
    sv          = 6'd0;
    dpos        = 3'd0;
    bad         = 1'b0;
    dpad        = pad_r;
    dbuf        = gbuf_r;
    dbytes      = 2'd0;
    if (accept) begin
      if (disc_r) begin
        // dropped until end of message
      end else if (dir_r == DIR_ENCRYPT) begin
        ecnt  = (gcnt_r == 2'd3) ? 2'd0 : gcnt_r;
        ebuf  = {gbuf_r[15:0], in_byte ^ kb0};
        ecnt1 = {1'b0, ecnt} + 3'd1;
        key_pos_nxt = p1;
        gbuf_nxt = ebuf;
        gcnt_nxt = ecnt1[1:0];
        if (ecnt1 == 3'd3 || in_last) begin
          case (ecnt1)
            3'd1:    eval_w = {ebuf[7:0], 16'd0};
            3'd2:    eval_w = {ebuf[15:0], 8'd0};
            default: eval_w = ebuf;
          endcase
          q_push = 1'b1;
          q_rec.bytes[0] = sextet_char(eval_w[23:18]);
          q_rec.bytes[1] = sextet_char(eval_w[17:12]);
          q_rec.bytes[2] = (ecnt1 >= 3'd2) ? sextet_char(eval_w[11:6]) : CH_PAD;
          q_rec.bytes[3] = (ecnt1 >= 3'd3) ? sextet_char(eval_w[5:0]) : CH_PAD;
          q_rec.cnt  = 3'd4;
          q_rec.last = in_last;
          gbuf_nxt = 24'd0;
          gcnt_nxt = 2'd0;
        end
      end else begin
        dec = char_sextet(in_byte);
        sv  = dec[5:0];
        if (in_byte == CH_PAD) begin
          if (gcnt_r < 2'd2) bad = 1'b1;
          else begin
            dpad = pad_r + 2'd1;
            sv   = 6'd0;
          end
        end else if (!dec[6] || pad_r != 2'd0) begin
          bad = 1'b1;
        end
        pad_nxt = dpad;
        if (!bad) begin
          dbuf = {gbuf_r[17:0], sv};
          gbuf_nxt = dbuf;
          dpos = {1'b0, gcnt_r} + 3'd1;
          if (dpos == 3'd4) begin
            if (dpad != 2'd0 && !in_last) begin
              bad = 1'b1;
            end else begin
              dbytes = (dpad == 2'd0) ? 2'd3 : (dpad == 2'd1) ? 2'd2 : 2'd1;
              q_push = 1'b1;
              q_rec.bytes[0] = dbuf[23:16] ^ kb0;
              q_rec.bytes[1] = dbuf[15:8] ^ kb1;
              q_rec.bytes[2] = dbuf[7:0] ^ kb2;
              q_rec.cnt  = {1'b0, dbytes};
              q_rec.last = in_last;
              case (dbytes)
                2'd1:    key_pos_nxt = p1;
                2'd2:    key_pos_nxt = p2;
                default: key_pos_nxt = p3;
              endcase
            end
            gbuf_nxt = 24'd0;
            pad_nxt  = 2'd0;
            gcnt_nxt = 2'd0;
          end else begin
            if (in_last) bad = 1'b1;
            gcnt_nxt = dpos[1:0];
          end
        end
        if (bad) begin
          q_push = 1'b1;
          q_rec  = '0;
          q_rec.cnt  = 3'd1;
          q_rec.last = in_last;
          q_rec.err  = 1'b1;
          if (!in_last) disc_nxt = 1'b1;
        end
      end
      if (in_last) begin
        key_pos_nxt = 4'd0;
        gbuf_nxt    = 24'd0;
        gcnt_nxt    = 2'd0;
        pad_nxt     = 2'd0;
        disc_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= DIR_ENCRYPT;
      key_lo_r  <= 64'd0;
      key_hi_r  <= 64'd0;
      key_len_r <= 5'd1;
      key_pos_r <= 4'd0;
      gbuf_r    <= 24'd0;
      gcnt_r    <= 2'd0;
      pad_r     <= 2'd0;
      disc_r    <= 1'b0;
    end else begin
      key_pos_r <= key_pos_nxt;
      gbuf_r    <= gbuf_nxt;
      gcnt_r    <= gcnt_nxt;
      pad_r     <= pad_nxt;
      disc_r    <= disc_nxt;
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_DIRECTION: dir_r     <= dir_t'(cfg_data[0]);
          REG_KEY_LOW:   key_lo_r  <= cfg_data;
          REG_KEY_HIGH:  key_hi_r  <= cfg_data;
          REG_KEY_LEN:   key_len_r <= cfg_data[4:0];
          default:       dir_r     <= dir_r;
        endcase
      end
    end
  end

endmodule

// ===== src/xb64_fifo.sv =====
// short queue of result groups between front and back end
module xb64_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  xb64_pkg::xb64_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output xb64_pkg::xb64_rec_t head
);
  import xb64_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  xb64_rec_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== src/xb64_back.sv =====
// back end: sends the bytes of each queued group one per cycle while out_ready is high
module xb64_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  xb64_pkg::xb64_rec_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_error
);
  import xb64_pkg::*;

  xb64_rec_t  cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       at_end;
  logic       done;
  logic       load;

  assign at_end    = (({1'b0, idx_r} + 3'd1) == cur_r.cnt);
  assign out_valid = cur_valid_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = cur_r.last && at_end;
  assign out_error = cur_r.err;
  assign done      = cur_valid_r && out_ready && at_end;
  assign load      = !cur_valid_r || done;
  assign q_pop     = load && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      cur_valid_r <= !q_empty;
      idx_r       <= 2'd0;
    end else if (out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

// ===== src/xor_base64_codec.sv =====
// top level of the repeating-key xor codec with base64 framing
//
// input items (in_byte, in_last) arrive on a valid/ready channel; results
// (out_byte, out_last, out_error) leave on another. direction 0 xors each
// byte with the running key byte and emits four base64 characters per group
// of three bytes, the item with in_last flushing a padded partial group.
// direction 1 gathers base64 characters in fours and emits one to three key
// xored bytes. bad characters, misplaced padding or a short final group give
// one item with out_error set; input is then dropped until in_last.
// configuration: cfg_we with cfg_index 0 direction, 1 and 2 key bytes, 3 key
// length; the user must see these are written only while the block is idle,
// which the block does not enforce. an item is classified in its accept cycle;
// its results pass the queue and output register before the first shows. with
// out_ready high the output stage sends one result per cycle, so sustained rate
// is set by the result count, lower when encoding (four characters per three bytes)
// than decoding. a stalled receiver fills the two-entry queue, then in_ready drops.
// synchronous reset clears the registers (key length 1) and message state.
module xor_base64_codec #(
  parameter int KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_error
);
  import xb64_pkg::*;

  xb64_rec_t push_rec;
  xb64_rec_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  xb64_front #(
    .KEY_BYTES(KEY_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (full),
    .q_push   (push),
    .q_rec    (push_rec)
  );

  xb64_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  xb64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (empty),
    .q_head   (head),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last),
    .out_error(out_error)
  );

endmodule
